/* hw/rtl/mfpe_pkg.sv */
// mfpe_pkg: command codes, status codes and controller states of the
// monochrome frame store pixel engine; no dependencies
`default_nettype none

package mfpe_pkg;

    typedef enum logic [2:0] {
        CMD_DRAW   = 3'd0,
        CMD_QUERY  = 3'd1,
        CMD_FILL   = 3'd2,
        CMD_INVERT = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_READ   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_RMW,
        ST_PUSH
    } t_state;

    localparam logic [1:0] PIX_DARK = 2'd0;
    localparam logic [1:0] PIX_LIT  = 2'd1;
    localparam logic [1:0] PIX_OFF  = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/monochrome_framebuffer_pixel_engine_core.sv */
// monochrome_framebuffer_pixel_engine_core: one-bit frame store of COLUMNS x
// PAGES bytes with point, query, rectangle, clear and byte read commands
// depends on mfpe_pkg
//
// usage: one command word enters on the s_axis channel (command in tuser,
// coordinates, value and page in tdata); every word gives exactly one result
// word on the m_axis channel (pixel status and stored byte, zero when unused).
// the frame lives in one synchronous memory of COLUMNS * 2**max(1,
// ceil(log2(PAGES))) bytes, addressed by column and page, with a registered read.
// draw point, query pixel and read byte read the byte, then modify and
// write back (or answer). off-panel points and unused codes are answered
// without a read-modify-write. fill and invert read and write back each page
// byte touched by the clipped rectangle, walked column by column, one
// read-modify-write per byte; invert with row_b off the panel stops after
// its first column. clear all sweeps the memory one byte a cycle.
// after reset the same sweep runs with s_axis tready low; no result word
// comes from it.
// the result sits in an output register; while the receiver stalls a new
// command may still be accepted and worked, and the engine waits only when
// its next result is ready and the register is still full.
`default_nettype none

module monochrome_framebuffer_pixel_engine_core #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // col_a, row_a, col_b, row_b, pixel_value, page_index, zero pad
    input  wire logic [39:0] i_s_axis_tdata,
    // command
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // pixel_status, stored_byte, zero pad
    output logic [15:0]      o_m_axis_tdata
);

    localparam int X_W    = $clog2(COLUMNS);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ROWS   = 8 * PAGES;
    localparam int RW     = (ROWS > 8) ? $clog2(ROWS) : 4;
    localparam int GW     = RW - 3;
    localparam int ADDR_W = X_W + PAGE_W;
    localparam int DEPTH  = COLUMNS * (2 ** PAGE_W);

    // memory
    logic [7:0]        mem [0:DEPTH-1];
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;
    logic [7:0]        r_rd_data;

    // control
    mfpe_pkg::t_state  r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_clr_resp, n_clr_resp;
    logic              r_out_valid, n_out_valid;

    // payload
    mfpe_pkg::t_cmd    r_op, n_op;
    logic              r_val, n_val;
    logic [7:0]        r_mask, n_mask;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [X_W-1:0]    r_x_cur, n_x_cur;
    logic [X_W-1:0]    r_x_end, n_x_end;
    logic [GW-1:0]     r_g_cur, n_g_cur;
    logic [RW-1:0]     r_row_lo, n_row_lo;
    logic [RW-1:0]     r_row_hi, n_row_hi;
    logic [1:0]        r_res_status, n_res_status;
    logic [7:0]        r_res_byte, n_res_byte;
    logic [1:0]        r_out_status, n_out_status;
    logic [7:0]        r_out_byte, n_out_byte;

    // input word fields
    mfpe_pkg::t_cmd    in_cmd;
    logic [7:0]        col_a, row_a, col_b, row_b;
    logic              in_val;
    logic [2:0]        in_pg;
    logic              s_acc;

    assign in_cmd = mfpe_pkg::t_cmd'(i_s_axis_tuser);
    assign col_a  = i_s_axis_tdata[7:0];
    assign row_a  = i_s_axis_tdata[15:8];
    assign col_b  = i_s_axis_tdata[23:16];
    assign row_b  = i_s_axis_tdata[31:24];
    assign in_val = i_s_axis_tdata[32];
    assign in_pg  = i_s_axis_tdata[35:33];
    assign o_s_axis_tready = (r_state == mfpe_pkg::ST_IDLE);
    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;

    // input decode
    logic              col_a_in, row_a_in, col_b_in, row_b_in, on_a, rect_ok, rb_ok;
    logic [ADDR_W-1:0] pt_addr, rb_addr;
    logic [7:0]        pt_mask;
    logic [X_W-1:0]    col_hi;
    logic [RW-1:0]     row_hi;

    assign col_a_in = {1'b0, col_a} < 9'(COLUMNS);
    assign row_a_in = {1'b0, row_a} < 9'(ROWS);
    assign col_b_in = {1'b0, col_b} < 9'(COLUMNS);
    assign row_b_in = {1'b0, row_b} < 9'(ROWS);
    assign on_a     = col_a_in && row_a_in;
    assign rect_ok  = on_a && (col_a <= col_b) && (row_a <= row_b);
    assign rb_ok    = col_a_in && ({2'b00, in_pg} < 5'(PAGES));
    assign pt_addr  = {col_a[X_W-1:0],
                       PAGE_W'(PAGES - 1) - PAGE_W'(row_a[RW-1:3])};
    assign rb_addr  = {col_a[X_W-1:0], PAGE_W'(in_pg)};
    assign pt_mask  = 8'h80 >> row_a[2:0];
    assign col_hi   = col_b_in ? col_b[X_W-1:0] : X_W'(COLUMNS - 1);
    assign row_hi   = row_b_in ? row_b[RW-1:0] : RW'(ROWS - 1);

    // rectangle walk
    logic [2:0]        w_lo, w_hi;
    logic [7:0]        walk_mask;
    logic [ADDR_W-1:0] walk_addr;
    logic              walk_last, is_walk, rmw_done, out_free, out_load;
    logic [7:0]        mod_byte;
    logic [1:0]        rmw_status;
    logic [7:0]        rmw_byte;

    assign w_lo      = (r_g_cur == r_row_lo[RW-1:3]) ? r_row_lo[2:0] : 3'd0;
    assign w_hi      = (r_g_cur == r_row_hi[RW-1:3]) ? r_row_hi[2:0] : 3'd7;
    assign walk_mask = (8'hFF >> w_lo) & (8'hFF << (3'd7 - w_hi));
    assign walk_addr = {r_x_cur, PAGE_W'(PAGES - 1) - PAGE_W'(r_g_cur)};
    assign walk_last = (r_g_cur == r_row_hi[RW-1:3]) && (r_x_cur == r_x_end);
    assign is_walk   = (r_op == mfpe_pkg::CMD_FILL) || (r_op == mfpe_pkg::CMD_INVERT);
    assign rmw_done  = !is_walk || walk_last;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign mod_byte  = (r_op == mfpe_pkg::CMD_INVERT) ? (r_rd_data ^ r_mask)
                     : ((r_rd_data & ~r_mask) | (r_val ? r_mask : 8'h00));
    assign rmw_status = (r_op == mfpe_pkg::CMD_QUERY)
                      ? (|(r_rd_data & r_mask) ? mfpe_pkg::PIX_LIT : mfpe_pkg::PIX_DARK)
                      : mfpe_pkg::PIX_DARK;
    assign rmw_byte   = (r_op == mfpe_pkg::CMD_READ) ? r_rd_data : 8'h00;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mfpe_pkg::ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = r_clr_resp ? mfpe_pkg::ST_PUSH : mfpe_pkg::ST_IDLE;
                end
            end
            mfpe_pkg::ST_IDLE: begin
                if (s_acc) begin
                    unique case (in_cmd)
                        mfpe_pkg::CMD_DRAW,
                        mfpe_pkg::CMD_QUERY:  n_state = on_a ? mfpe_pkg::ST_RMW
                                                             : mfpe_pkg::ST_PUSH;
                        mfpe_pkg::CMD_FILL,
                        mfpe_pkg::CMD_INVERT: n_state = rect_ok ? mfpe_pkg::ST_RD
                                                                : mfpe_pkg::ST_PUSH;
                        mfpe_pkg::CMD_CLEAR:  n_state = mfpe_pkg::ST_CLEAR;
                        mfpe_pkg::CMD_READ:   n_state = rb_ok ? mfpe_pkg::ST_RMW
                                                              : mfpe_pkg::ST_PUSH;
                        default:              n_state = mfpe_pkg::ST_PUSH;
                    endcase
                end
            end
            mfpe_pkg::ST_RD: begin
                n_state = mfpe_pkg::ST_RMW;
            end
            mfpe_pkg::ST_RMW: begin
                if (!rmw_done) begin
                    n_state = mfpe_pkg::ST_RD;
                end else if (out_free) begin
                    n_state = mfpe_pkg::ST_IDLE;
                end else begin
                    n_state = mfpe_pkg::ST_PUSH;
                end
            end
            mfpe_pkg::ST_PUSH: begin
                if (out_free) begin
                    n_state = mfpe_pkg::ST_IDLE;
                end
            end
            default: n_state = mfpe_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        mem_re       = 1'b0;
        mem_ra       = pt_addr;
        mem_we       = 1'b0;
        mem_wa       = r_addr;
        mem_wd       = mod_byte;
        out_load     = 1'b0;
        n_clr_addr   = r_clr_addr;
        n_clr_resp   = r_clr_resp;
        n_op         = r_op;
        n_val        = r_val;
        n_mask       = r_mask;
        n_addr       = r_addr;
        n_x_cur      = r_x_cur;
        n_x_end      = r_x_end;
        n_g_cur      = r_g_cur;
        n_row_lo     = r_row_lo;
        n_row_hi     = r_row_hi;
        n_res_status = r_res_status;
        n_res_byte   = r_res_byte;
        n_out_status = r_out_status;
        n_out_byte   = r_out_byte;
        unique case (r_state)
            mfpe_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_wa     = r_clr_addr;
                mem_wd     = 8'h00;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            mfpe_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_op         = in_cmd;
                    n_val        = in_val;
                    n_mask       = pt_mask;
                    n_addr       = (in_cmd == mfpe_pkg::CMD_READ) ? rb_addr : pt_addr;
                    n_x_cur      = col_a[X_W-1:0];
                    n_x_end      = (in_cmd == mfpe_pkg::CMD_INVERT && !row_b_in)
                                 ? col_a[X_W-1:0] : col_hi;
                    n_g_cur      = row_a[RW-1:3];
                    n_row_lo     = row_a[RW-1:0];
                    n_row_hi     = row_hi;
                    n_res_status = (in_cmd == mfpe_pkg::CMD_QUERY && !on_a)
                                 ? mfpe_pkg::PIX_OFF : mfpe_pkg::PIX_DARK;
                    n_res_byte   = 8'h00;
                    n_clr_addr   = '0;
                    n_clr_resp   = 1'b1;
                    mem_re       = 1'b1;
                    mem_ra       = (in_cmd == mfpe_pkg::CMD_READ) ? rb_addr : pt_addr;
                end
            end
            mfpe_pkg::ST_RD: begin
                mem_re = 1'b1;
                mem_ra = walk_addr;
                n_addr = walk_addr;
                n_mask = walk_mask;
            end
            mfpe_pkg::ST_RMW: begin
                mem_we = (r_op == mfpe_pkg::CMD_DRAW) || is_walk;
                if (!rmw_done) begin
                    if (r_g_cur == r_row_hi[RW-1:3]) begin
                        n_x_cur = r_x_cur + 1'b1;
                        n_g_cur = r_row_lo[RW-1:3];
                    end else begin
                        n_g_cur = r_g_cur + 1'b1;
                    end
                end else begin
                    n_res_status = rmw_status;
                    n_res_byte   = rmw_byte;
                    out_load     = out_free;
                    n_out_status = rmw_status;
                    n_out_byte   = rmw_byte;
                end
            end
            mfpe_pkg::ST_PUSH: begin
                out_load     = out_free;
                n_out_status = r_res_status;
                n_out_byte   = r_res_byte;
            end
            default: ;
        endcase
        if (!out_load) begin
            n_out_status = r_out_status;
            n_out_byte   = r_out_byte;
        end
        n_out_valid = out_load || (r_out_valid && !i_m_axis_tready);
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b000000, r_out_byte, r_out_status};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfpe_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_resp  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_resp  <= n_clr_resp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_val        <= n_val;
        r_mask       <= n_mask;
        r_addr       <= n_addr;
        r_x_cur      <= n_x_cur;
        r_x_end      <= n_x_end;
        r_g_cur      <= n_g_cur;
        r_row_lo     <= n_row_lo;
        r_row_hi     <= n_row_hi;
        r_res_status <= n_res_status;
        r_res_byte   <= n_res_byte;
        r_out_status <= n_out_status;
        r_out_byte   <= n_out_byte;
    end

`ifndef SYNTHESIS
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfpe_pkg::ST_CLEAR) |-> !o_s_axis_tready)
        else $error("command accepted during clearing sweep");

    a_rmw_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfpe_pkg::ST_RMW) |->
            ($past(r_state) == mfpe_pkg::ST_IDLE || $past(r_state) == mfpe_pkg::ST_RD))
        else $error("write back without a preceding read");

    a_walk_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfpe_pkg::ST_RD) |-> (r_x_cur <= r_x_end && r_g_cur <= r_row_hi[RW-1:3]))
        else $error("rectangle walk past its end");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status != 2'd3))
        else $error("invalid pixel status");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> !$past(out_load))
        else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_monochrome_framebuffer_pixel_engine_core.sv */
// tb_monochrome_framebuffer_pixel_engine_core: self-checking bench for the frame store engine,
// directed corner cases then random command streams, predicted against a frame model
// depends on mfpe_pkg and monochrome_framebuffer_pixel_engine_core

module tb_monochrome_framebuffer_pixel_engine_core;

    localparam int COLS       = 128;
    localparam int PAGE_CNT   = 8;
    localparam int ROWS       = PAGE_CNT * 8;
    localparam int CYCLE_CAP  = 10_000_000;
    localparam int DRAIN_WAIT = 100;

    // codes the block accepts but does nothing with
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic [3:0] pad;
        logic [2:0] page;
        logic       value;
        logic [7:0] row_b;
        logic [7:0] col_b;
        logic [7:0] row_a;
        logic [7:0] col_a;
    } t_cmd_word;

    typedef struct packed {
        logic [5:0] pad;
        logic [7:0] stored;
        logic [1:0] status;
    } t_result_word;

    class frame_scoreboard;
        logic [7:0]   frame [COLS][PAGE_CNT];
        t_result_word expected_q [$];
        int           errors;

        function new();
            errors = 0;
            wipe_frame();
        endfunction

        function void wipe_frame();
            foreach (frame[x, p]) frame[x][p] = 8'h00;
        endfunction

        function bit on_panel(int x, int y);
            return (x < COLS) && (y < ROWS);
        endfunction

        function void write_pixel(int x, int y, logic v);
            if (on_panel(x, y)) frame[x][PAGE_CNT - 1 - y / 8][7 - y % 8] = v;
        endfunction

        function void toggle_pixel(int x, int y);
            frame[x][PAGE_CNT - 1 - y / 8][7 - y % 8] = ~frame[x][PAGE_CNT - 1 - y / 8][7 - y % 8];
        endfunction

        function logic [1:0] pixel_at(int x, int y);
            if (!on_panel(x, y)) return mfpe_pkg::PIX_OFF;
            return frame[x][PAGE_CNT - 1 - y / 8][7 - y % 8] ? mfpe_pkg::PIX_LIT
                                                             : mfpe_pkg::PIX_DARK;
        endfunction

        // apply one accepted command word to the frame and queue its answer
        function void note_command(logic [2:0] cmd, t_cmd_word w);
            t_result_word r;
            int x, y;
            bit halted;
            r = '0;
            halted = 1'b0;
            case (cmd)
                mfpe_pkg::CMD_DRAW: write_pixel(w.col_a, w.row_a, w.value);
                mfpe_pkg::CMD_QUERY: r.status = pixel_at(w.col_a, w.row_a);
                mfpe_pkg::CMD_FILL: begin
                    for (x = w.col_a; x <= w.col_b; x++)
                        for (y = w.row_a; y <= w.row_b; y++)
                            write_pixel(x, y, w.value);
                end
                mfpe_pkg::CMD_INVERT: begin
                    for (x = w.col_a; x <= w.col_b && !halted; x++)
                        for (y = w.row_a; y <= w.row_b && !halted; y++)
                            if (!on_panel(x, y)) halted = 1'b1;
                            else toggle_pixel(x, y);
                end
                mfpe_pkg::CMD_CLEAR: wipe_frame();
                mfpe_pkg::CMD_READ: begin
                    if (w.col_a < COLS && w.page < PAGE_CNT) r.stored = frame[w.col_a][w.page];
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(t_result_word got);
            t_result_word want;
            if (expected_q.size() == 0) begin
                $display("%0t: result word status %0d byte %02h with nothing expected",
                         $time, got.status, got.stored);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: pixel_status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.stored !== want.stored) begin
                $display("%0t: stored_byte expected %02h actual %02h",
                         $time, want.stored, got.stored);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk     = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic [39:0] cmd_data  = '0;
    logic [2:0]  cmd_user  = '0;
    logic        rx_ready  = 1'b0;
    logic        cmd_ready;
    logic        res_valid;
    logic [15:0] res_data;

    int send_idle_pct = 33;
    int recv_idle_pct = 66;
    int cycle_count   = 0;

    frame_scoreboard sb;

    monochrome_framebuffer_pixel_engine_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (cmd_valid),
        .o_s_axis_tready (cmd_ready),
        .i_s_axis_tdata  (cmd_data),
        .i_s_axis_tuser  (cmd_user),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (rx_ready),
        .o_m_axis_tdata  (res_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("monochrome_framebuffer_pixel_engine_core regression: fail");
            $finish;
        end
    end

    // result side: check at the edge, then pick the next ready level
    always @(posedge i_clk) begin
        if (rst_n && rx_ready && res_valid) sb.check_result(res_data);
        rx_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input logic [2:0] cmd, input t_cmd_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= w;
        cmd_user  <= cmd;
        do @(posedge i_clk); while (!cmd_ready);
        sb.note_command(cmd, w);
    endtask

    task automatic issue(input logic [2:0] cmd, input int ca, input int ra, input int cb,
                         input int rb, input logic v, input int pg);
        t_cmd_word w;
        w = '0;
        w.col_a = 8'(ca);
        w.row_a = 8'(ra);
        w.col_b = 8'(cb);
        w.row_b = 8'(rb);
        w.value = v;
        w.page  = 3'(pg);
        send_word(cmd, w);
    endtask

    function automatic int pick_col();
        return ($urandom_range(99) < 80) ? $urandom_range(COLS - 1) : $urandom_range(255);
    endfunction

    function automatic int pick_row();
        return ($urandom_range(99) < 80) ? $urandom_range(ROWS - 1) : $urandom_range(255);
    endfunction

    // mostly short spans so wide rectangles stay rare
    function automatic int rect_end(int start);
        int e;
        if ($urandom_range(99) < 85) begin
            e = start + $urandom_range(15);
            return (e > 255) ? 255 : e;
        end
        return $urandom_range(255);
    endfunction

    task automatic run_directed();
        issue(mfpe_pkg::CMD_QUERY,   0,   0,   0,   0, 1'b0, 0);
        issue(mfpe_pkg::CMD_DRAW,    0,   0,   0,   0, 1'b1, 0);
        issue(mfpe_pkg::CMD_QUERY,   0,   0,   0,   0, 1'b0, 0);
        issue(mfpe_pkg::CMD_DRAW,  127,  63,   0,   0, 1'b1, 0);
        issue(mfpe_pkg::CMD_READ,  127,   0,   0,   0, 1'b0, 0);
        issue(mfpe_pkg::CMD_READ,    0,   0,   0,   0, 1'b0, 7);
        issue(mfpe_pkg::CMD_DRAW,  128,   5,   0,   0, 1'b1, 0);
        issue(mfpe_pkg::CMD_QUERY, 128,   5,   0,   0, 1'b0, 0);
        issue(mfpe_pkg::CMD_QUERY,   5,  64,   0,   0, 1'b0, 0);
        issue(mfpe_pkg::CMD_QUERY, 255, 255, 255, 255, 1'b1, 7);
        issue(mfpe_pkg::CMD_DRAW,    0,   0,   0,   0, 1'b0, 0);
        // clipped fill, then empty column range and empty row range
        issue(mfpe_pkg::CMD_FILL,   10,  60, 140,  70, 1'b1, 0);
        issue(mfpe_pkg::CMD_READ,   20,   0,   0,   0, 1'b0, 0);
        issue(mfpe_pkg::CMD_FILL,   50,  10,  40,  20, 1'b1, 0);
        issue(mfpe_pkg::CMD_FILL,    5,  30,   6,  20, 1'b1, 0);
        // invert stops at the first point off the panel
        issue(mfpe_pkg::CMD_INVERT, 120, 62, 130,  63, 1'b0, 0);
        issue(mfpe_pkg::CMD_READ,  125,   0,   0,   0, 1'b0, 0);
        issue(mfpe_pkg::CMD_INVERT,   3, 62,   4,  66, 1'b0, 0);
        issue(mfpe_pkg::CMD_READ,    4,   0,   0,   0, 1'b0, 0);
        // end bounds of 255
        issue(mfpe_pkg::CMD_FILL,  126,   0, 255,   1, 1'b1, 0);
        issue(mfpe_pkg::CMD_INVERT,   0,  0, 255, 255, 1'b0, 0);
        issue(mfpe_pkg::CMD_READ,    0,   4,   0,   0, 1'b1, 4);
        issue(CMD_SPARE_A, 1,   2,   3,   4, 1'b1, 5);
        issue(CMD_SPARE_B, 255, 255, 255, 255, 1'b1, 7);
        issue(mfpe_pkg::CMD_READ,  200,   0,   0,   0, 1'b0, 3);
        issue(mfpe_pkg::CMD_CLEAR,  33,  33,  33,  33, 1'b1, 2);
        issue(mfpe_pkg::CMD_READ,  127,   0,   0,   0, 1'b0, 0);
    endtask

    task automatic run_random(input int count);
        t_cmd_word w;
        logic [2:0] cmd;
        int sel;
        repeat (count) begin
            w = '0;
            w.col_a = 8'(pick_col());
            w.row_a = 8'(pick_row());
            w.col_b = 8'(rect_end(w.col_a));
            w.row_b = 8'(rect_end(w.row_a));
            w.value = 1'($urandom_range(1));
            w.page  = 3'($urandom_range(7));
            sel = $urandom_range(99);
            if (sel < 18)      cmd = mfpe_pkg::CMD_DRAW;
            else if (sel < 38) cmd = mfpe_pkg::CMD_QUERY;
            else if (sel < 50) cmd = mfpe_pkg::CMD_FILL;
            else if (sel < 62) cmd = mfpe_pkg::CMD_INVERT;
            else if (sel < 64) cmd = mfpe_pkg::CMD_CLEAR;
            else if (sel < 96) cmd = mfpe_pkg::CMD_READ;
            else if (sel < 98) cmd = CMD_SPARE_A;
            else               cmd = CMD_SPARE_B;
            send_word(cmd, w);
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        send_idle_pct = 33;
        recv_idle_pct = 66;
        run_directed();
        run_random(310);
        send_idle_pct = 66;
        recv_idle_pct = 33;
        run_random(310);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(310);
        cmd_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("monochrome_framebuffer_pixel_engine_core regression: pass");
        end else begin
            $display("monochrome_framebuffer_pixel_engine_core regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mfpe_pkg.sv
hw/rtl/monochrome_framebuffer_pixel_engine_core.sv
tb/sv/tb_monochrome_framebuffer_pixel_engine_core.sv
